### rtl/core/rbd_pkg.sv
// Shared types, codes and default sizes for the ring buffer deque.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

### rtl/core/ring_buffer_deque.sv
// Ring buffer deque: push/pop at either end, positional read, clear.
// Every command gives its result in the cycle after acceptance (done high).
// Throughput: one command per cycle outside reset; the storage RAM has one write and one read port.
// busy is high only while rst is asserted.
// Reset (rst, synchronous) empties the queue and zeroes both pointers; RAM
// contents are not cleared, and the receiver cannot stall results.
`timescale 1ns / 1ps

module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rbd_pkg::CMD_W-1:0]    cmd,
  input  logic [rbd_pkg::VALUE_W-1:0]  value,
  input  logic [rbd_pkg::POS_W-1:0]    position,
  output logic                         busy,
  output logic                         done,
  output logic [rbd_pkg::VALUE_W-1:0]  read_data,
  output logic [rbd_pkg::COUNT_W-1:0]  count,
  output logic [rbd_pkg::STATUS_W-1:0] status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((PW > rbd_pkg::POS_W) ? PW : rbd_pkg::POS_W) + 1;
  localparam int MW = (CW > rbd_pkg::POS_W) ? CW : rbd_pkg::POS_W;

  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  logic [PW-1:0] front_ptr, front_ptr_next;
  logic [PW-1:0] back_ptr, back_ptr_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic [rbd_pkg::STATUS_W-1:0] status_next;
  logic rd_ok, rd_ok_next;

  logic accept;
  logic full, empty, pos_ok;
  logic [PW-1:0] front_dec, front_inc, back_dec, back_inc;
  logic [SW-1:0] pos_sum;
  logic [PW-1:0] rd_addr;

  logic                  we;
  logic [PW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [DATA_WIDTH-1:0] rdata;
  logic [rbd_pkg::VALUE_W-1:0] rd_ext;

  assign busy   = rst;
  assign accept = start && !busy;

  assign full  = (fill_count == CW'(DEPTH));
  assign empty = (fill_count == '0);
  assign pos_ok = (MW'(position) < MW'(fill_count));

  assign front_dec = (front_ptr == '0) ? LAST_IDX : front_ptr - 1'b1;
  assign front_inc = (front_ptr == LAST_IDX) ? '0 : front_ptr + 1'b1;
  assign back_dec  = (back_ptr == '0) ? LAST_IDX : back_ptr - 1'b1;
  assign back_inc  = (back_ptr == LAST_IDX) ? '0 : back_ptr + 1'b1;

  // Position is below the fill count when used, so one wrap correction is enough.
  assign pos_sum = SW'(front_ptr) + SW'(position);
  assign rd_addr = (pos_sum >= SW'(DEPTH)) ? PW'(pos_sum - SW'(DEPTH)) : PW'(pos_sum);

  // Keep the low DATA_WIDTH bits of the value; zero-fill above the field.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_wdata
    if (i < rbd_pkg::VALUE_W) begin : g_bit
      assign wdata[i] = value[i];
    end else begin : g_zero
      assign wdata[i] = 1'b0;
    end
  end

  always_comb begin
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    fill_count_next = fill_count;
    status_next     = rbd_pkg::ST_OK;
    rd_ok_next      = 1'b0;
    we              = 1'b0;
    waddr           = back_ptr;
    re              = 1'b0;
    if (accept) begin
      case (cmd)
        rbd_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = rbd_pkg::ST_FULL;
          end else begin
            we              = 1'b1;
            waddr           = front_dec;
            front_ptr_next  = front_dec;
            fill_count_next = fill_count + 1'b1;
          end
        end
        rbd_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_next = rbd_pkg::ST_FULL;
          end else begin
            we              = 1'b1;
            waddr           = back_ptr;
            back_ptr_next   = back_inc;
            fill_count_next = fill_count + 1'b1;
          end
        end
        rbd_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_next = rbd_pkg::ST_EMPTY;
          end else begin
            front_ptr_next  = front_inc;
            fill_count_next = fill_count - 1'b1;
          end
        end
        rbd_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_next = rbd_pkg::ST_EMPTY;
          end else begin
            back_ptr_next   = back_dec;
            fill_count_next = fill_count - 1'b1;
          end
        end
        rbd_pkg::CMD_READ: begin
          if (pos_ok) begin
            re         = 1'b1;
            rd_ok_next = 1'b1;
          end else begin
            status_next = rbd_pkg::ST_RANGE;
          end
        end
        rbd_pkg::CMD_CLEAR: begin
          front_ptr_next  = back_ptr;
          fill_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr  <= '0;
      back_ptr   <= '0;
      fill_count <= '0;
      done       <= 1'b0;
      rd_ok      <= 1'b0;
      status     <= rbd_pkg::ST_OK;
    end else begin
      front_ptr  <= front_ptr_next;
      back_ptr   <= back_ptr_next;
      fill_count <= fill_count_next;
      done       <= accept;
      rd_ok      <= rd_ok_next;
      status     <= status_next;
    end
  end

  rbd_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  for (genvar i = 0; i < rbd_pkg::VALUE_W; i++) begin : g_rdata
    if (i < DATA_WIDTH) begin : g_bit
      assign rd_ext[i] = rdata[i];
    end else begin : g_zero
      assign rd_ext[i] = 1'b0;
    end
  end

  // Drop the RAM output unless done reports a successful read.
  assign read_data = rd_ok ? rd_ext : '0;

  // Report the fill count modulo the width of the count field.
  for (genvar i = 0; i < rbd_pkg::COUNT_W; i++) begin : g_count
    if (i < CW) begin : g_bit
      assign count[i] = fill_count[i];
    end else begin : g_zero
      assign count[i] = 1'b0;
    end
  end

endmodule

### rtl/core/rbd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int WIDTH = rbd_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### test/deque_checker.sv
// Checker for the ring buffer deque: predicts each result and compares it.
`timescale 1ns / 1ps

module deque_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rbd_pkg::CMD_W-1:0]    cmd,
  input  logic [rbd_pkg::VALUE_W-1:0]  value,
  input  logic [rbd_pkg::POS_W-1:0]    position,
  input  logic                         done,
  input  logic [rbd_pkg::VALUE_W-1:0]  read_data,
  input  logic [rbd_pkg::COUNT_W-1:0]  count,
  input  logic [rbd_pkg::STATUS_W-1:0] status,
  output int                           fail_count,
  output int                           pending
);

  import rbd_pkg::*;

  localparam int SLOTS = DEPTH_DEF;

  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } deque_result_t;

  // Shadow copy of the deque.
  logic [VALUE_W-1:0] deque_mem [SLOTS];
  logic [POS_W-1:0]   head_idx;
  logic [POS_W-1:0]   tail_idx;
  logic [COUNT_W-1:0] held;

  deque_result_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    head_idx   = '0;
    tail_idx   = '0;
    held       = '0;
  end

  task automatic apply_command(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                               input logic [POS_W-1:0] p, output deque_result_t r);
    logic [POS_W-1:0] slot;
    r.read_data = '0;
    r.status    = ST_OK;
    case (c)
      CMD_PUSH_FRONT: begin
        if (held == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          head_idx = head_idx - 1'b1;
          deque_mem[head_idx] = v;
          held = held + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (held == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          deque_mem[tail_idx] = v;
          tail_idx = tail_idx + 1'b1;
          held = held + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_idx = head_idx + 1'b1;
          held = held - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_idx = tail_idx - 1'b1;
          held = held - 1'b1;
        end
      end
      CMD_READ: begin
        if (p >= held) begin
          r.status = ST_RANGE;
        end else begin
          slot = head_idx + p;
          r.read_data = deque_mem[slot];
        end
      end
      CMD_CLEAR: begin
        head_idx = tail_idx;
        held = '0;
      end
      default: ;
    endcase
    r.count = held;
  endtask

  always @(posedge clk) begin : watch
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      head_idx = '0;
      tail_idx = '0;
      held     = '0;
      awaited_results.delete();
    end else begin
      // Retire the finished item before taking the one accepted at this edge.
      if (done) begin
        got.read_data = read_data;
        got.count     = count;
        got.status    = status_t'(status);
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result read_data=%h count=%0d status=%0d",
                   $time, read_data, count, status);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected data=%h count=%0d status=%0d, got %h %0d %0d",
                     $time, want.read_data, want.count, want.status,
                     got.read_data, got.count, got.status);
          end
        end
      end
      if (start && !busy) begin
        apply_command(cmd, value, position, want);
        awaited_results.insert(awaited_results.size(), want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

### test/tb.sv
// Testbench top for the ring buffer deque: drives commands and reports the verdict.
`timescale 1ns / 1ps

module tb;

  import rbd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1750;

  logic                clk;
  logic                rst;
  logic                start;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  value;
  logic [POS_W-1:0]    position;
  logic                busy;
  logic                done;
  logic [VALUE_W-1:0]  read_data;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;
  int                  fail_count;
  int                  pending;

  ring_buffer_deque u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .busy      (busy),
    .done      (done),
    .read_data (read_data),
    .count     (count),
    .status    (status)
  );

  deque_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .done       (done),
    .read_data  (read_data),
    .count      (count),
    .status     (status),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] p);
    @(negedge clk);
    start    <= 1'b1;
    cmd      <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Mode 0 leans toward filling, mode 1 toward draining, mode 2 is balanced.
  task automatic pick_cmd(input int mode, output logic [CMD_W-1:0] c,
                          output logic [VALUE_W-1:0] v, output logic [POS_W-1:0] p);
    int roll;
    int push_lim;
    int pop_lim;
    int read_lim;
    int clear_lim;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin push_lim = 60; pop_lim = 68; read_lim = 97; clear_lim = 98; end
      1: begin push_lim = 15; pop_lim = 60; read_lim = 93; clear_lim = 96; end
      default: begin push_lim = 35; pop_lim = 65; read_lim = 95; clear_lim = 97; end
    endcase
    if (roll < push_lim) begin
      c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (roll < pop_lim) begin
      c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else if (roll < read_lim) begin
      c = CMD_READ;
    end else if (roll < clear_lim) begin
      c = CMD_CLEAR;
    end else begin
      c = $urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO;
    end
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    p = POS_W'($urandom_range(0, 15));
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    int mode;
    int w;
    logic [CMD_W-1:0]   c;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   p;

    rst      = 1'b1;
    start    = 1'b0;
    cmd      = CMD_PUSH_FRONT;
    value    = '0;
    position = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty queue: refused pops and read, no-op codes, clear with nothing held.
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_READ, '0, '0);
    send_cmd(CMD_NOP_LO, '1, '1);
    send_cmd(CMD_NOP_HI, '0, '0);
    send_cmd(CMD_CLEAR, '0, '0);
    // Wrap the front pointer below zero, then fill to capacity.
    send_cmd(CMD_PUSH_FRONT, '0, '0);
    send_cmd(CMD_PUSH_BACK, '1, '0);
    send_cmd(CMD_READ, '0, 4'd0);
    send_cmd(CMD_READ, '0, 4'd15);
    for (int i = 0; i < 14; i++) begin
      send_cmd(CMD_PUSH_BACK, $urandom, '0);
    end
    send_cmd(CMD_PUSH_FRONT, '1, '0);
    send_cmd(CMD_PUSH_BACK, '1, '0);
    send_cmd(CMD_READ, '0, 4'd15);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_READ, '0, 4'd0);
    idle(3);

    sent = 0;
    mode = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        if (sent % 48 == 0) mode = $urandom_range(0, 2);
        pick_cmd(mode, c, v, p);
        send_cmd(c, v, p);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    end
    idle(1);

    w = 0;
    while (pending != 0 && w < 50) begin
      @(negedge clk);
      w++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_ram.sv
rtl/core/ring_buffer_deque.sv
test/deque_checker.sv
test/tb.sv
